[src/emst_pkg.sv]
// shared types and constants of the euclidean mst length block
// no dependencies; imported by the controller, the datapath and the top level
package emst_pkg;

   localparam logic [30:0] LEN_MAX = 31'h7FFF_FFFF;

   typedef enum logic [12:0] {
      S_LOAD  = 13'b0000000000001,
      S_START = 13'b0000000000010,
      S_UREAD = 13'b0000000000100,
      S_ULAT  = 13'b0000000001000,
      S_VREAD = 13'b0000000010000,
      S_VCHK  = 13'b0000000100000,
      S_MUL   = 13'b0000001000000,
      S_UPD   = 13'b0000010000000,
      S_VNEXT = 13'b0000100000000,
      S_MARK  = 13'b0001000000000,
      S_SQRT  = 13'b0010000000000,
      S_ACC   = 13'b0100000000000,
      S_FIN   = 13'b1000000000000
   } state_type;

   typedef struct packed {
      logic capture;
      logic start;
      logic uread;
      logic ulatch;
      logic vread;
      logic vcheck;
      logic mul_step;
      logic upd;
      logic vnext;
      logic mark;
      logic sqrt_step;
      logic acc;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic single;
      logic skip;
      logic mul_done;
      logic scan_end;
      logic sqrt_done;
      logic all_added;
      logic rsp_busy;
   } status_type;

endpackage

[src/emst_req_if.sv]
// point channel: valid/ready with one point per beat
// no dependencies
interface emst_req_if #(parameter int COORD_BITS = 24);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] point_x;
   logic signed [COORD_BITS-1:0] point_y;
   logic                         last_point;

   modport source (output valid, point_x, point_y, last_point, input ready);
   modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

[src/emst_rsp_if.sv]
// result channel: valid/ready with one tree length per beat
// no dependencies
interface emst_rsp_if;
   logic        valid;
   logic        ready;
   logic [30:0] total_length;
   logic [6:0]  point_count;
   logic        overflow;

   modport source (output valid, total_length, point_count, overflow, input ready);
   modport sink   (input valid, total_length, point_count, overflow, output ready);
endinterface

[src/emst_ctrl.sv]
// sequencer for point loading and the prim scan over the stored points
// depends on emst_pkg for the state, command and status types
module emst_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic                in_last,
   output logic                in_ready,
   output emst_pkg::cmd_type    cmd,
   input  emst_pkg::status_type stat
);
   import emst_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      in_ready = 1'b0;
      unique case (state_ff)
         S_LOAD: begin
            in_ready    = 1'b1;
            cmd.capture = in_valid;
            if (in_valid && in_last) state_in = S_START;
         end
         S_START: begin
            cmd.start = 1'b1;
            state_in  = stat.single ? S_FIN : S_UREAD;
         end
         S_UREAD: begin
            cmd.uread = 1'b1;
            state_in  = S_ULAT;
         end
         S_ULAT: begin
            cmd.ulatch = 1'b1;
            state_in   = S_VREAD;
         end
         S_VREAD: begin
            cmd.vread = 1'b1;
            state_in  = S_VCHK;
         end
         S_VCHK: begin
            cmd.vcheck = 1'b1;
            state_in   = stat.skip ? S_VNEXT : S_MUL;
         end
         S_MUL: begin
            cmd.mul_step = 1'b1;
            if (stat.mul_done) state_in = S_UPD;
         end
         S_UPD: begin
            cmd.upd  = 1'b1;
            state_in = S_VNEXT;
         end
         S_VNEXT: begin
            cmd.vnext = 1'b1;
            state_in  = stat.scan_end ? S_MARK : S_VREAD;
         end
         S_MARK: begin
            cmd.mark = 1'b1;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (stat.sqrt_done) state_in = S_ACC;
         end
         S_ACC: begin
            cmd.acc  = 1'b1;
            state_in = stat.all_added ? S_FIN : S_UREAD;
         end
         S_FIN: begin
            if (!stat.rsp_busy) begin
               cmd.emit = 1'b1;
               state_in = S_LOAD;
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_LOAD;
      else       state_ff <= state_in;
   end

endmodule

[src/emst_dp.sv]
// datapath: point and key memories, serial squarer, digit square root, result register
// depends on emst_pkg for command and status types and the length limit
module emst_dp #(
   parameter int MAX_POINTS = 64,
   parameter int COORD_BITS = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic signed [COORD_BITS-1:0] in_x,
   input  logic signed [COORD_BITS-1:0] in_y,
   input  emst_pkg::cmd_type             cmd,
   output emst_pkg::status_type          stat,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output logic [30:0]                  total_length,
   output logic [6:0]                   point_count,
   output logic                         overflow
);
   import emst_pkg::*;

   localparam int C  = COORD_BITS;
   localparam int DW = 2 * C + 1;
   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int MW = $clog2(2 * C);
   localparam int SW = ((DW > 32) ? DW : 32) + 1;

   logic [2*C-1:0] pt_mem [MAX_POINTS];
   logic [DW:0]    key_mem [MAX_POINTS];
   logic [2*C-1:0] pt_rd_ff;
   logic [DW:0]    key_rd_ff;

   logic [CW-1:0]   count_ff, count_in;
   logic            drop_ff, drop_in;
   logic signed [C-1:0] xu_ff, xu_in, yu_ff, yu_in;
   logic [AW-1:0]   v_ff, v_in, u_ff, u_in, best_ff, best_in;
   logic            first_ff, first_in, best_set_ff, best_set_in;
   logic [CW-1:0]   added_ff, added_in;
   logic [DW-1:0]   bestkey_ff, bestkey_in;
   logic [C-1:0]    op_ff, op_in, sh_ff, sh_in, my_ff, my_in;
   logic [2*C-1:0]  sq_ff, sq_in;
   logic [DW-1:0]   sum_ff, sum_in, dist_ff, dist_in;
   logic [MW-1:0]   cnt_ff, cnt_in;
   logic [DW-1:0]   rem_ff, rem_in, res_ff, res_in, one_ff, one_in;
   logic [30:0]     total_ff, total_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [30:0]     rsp_total_ff, rsp_total_in;
   logic [6:0]      rsp_count_ff, rsp_count_in;
   logic            rsp_ovf_ff, rsp_ovf_in;

   logic                full;
   logic signed [C-1:0] pt_x, pt_y;
   logic signed [C:0]   diff_x, diff_y, neg_x, neg_y;
   logic [C-1:0]        mag_x, mag_y;
   logic [2*C-1:0]      sq_next;
   logic [DW-1:0]       key_val, newkey, trial;
   logic [SW-1:0]       len_sum;
   logic [AW-1:0]       pt_raddr, key_waddr;
   logic [DW:0]         key_wdata;
   logic                key_we;

   assign full   = count_ff == CW'(MAX_POINTS);
   assign pt_x   = pt_rd_ff[2*C-1:C];
   assign pt_y   = pt_rd_ff[C-1:0];
   assign diff_x = {pt_x[C-1], pt_x} - {xu_ff[C-1], xu_ff};
   assign diff_y = {pt_y[C-1], pt_y} - {yu_ff[C-1], yu_ff};
   assign neg_x  = -diff_x;
   assign neg_y  = -diff_y;
   assign mag_x  = diff_x[C] ? neg_x[C-1:0] : diff_x[C-1:0];
   assign mag_y  = diff_y[C] ? neg_y[C-1:0] : diff_y[C-1:0];
   // msb-first shift-add square
   assign sq_next = {sq_ff[2*C-2:0], 1'b0} + (sh_ff[C-1] ? {{C{1'b0}}, op_ff} : '0);
   assign key_val = key_rd_ff[DW-1:0];
   assign newkey  = (first_ff || (dist_ff < key_val)) ? dist_ff : key_val;
   assign trial   = res_ff + one_ff;
   assign len_sum = SW'(total_ff) + SW'(res_ff);

   assign pt_raddr  = cmd.uread ? u_ff : v_ff;
   assign key_we    = cmd.upd || cmd.mark;
   assign key_waddr = cmd.upd ? v_ff : best_ff;
   // top bit marks a vertex already in the tree
   assign key_wdata = cmd.upd ? {1'b0, newkey} : {1'b1, bestkey_ff};

   always_ff @(posedge clock) begin
      if (cmd.capture && !full) pt_mem[count_ff[AW-1:0]] <= {in_x, in_y};
      if (cmd.uread || cmd.vread) pt_rd_ff <= pt_mem[pt_raddr];
      if (key_we) key_mem[key_waddr] <= key_wdata;
      if (cmd.vread) key_rd_ff <= key_mem[v_ff];
   end

   always_comb begin
      count_in = count_ff;   drop_in = drop_ff;
      xu_in = xu_ff;         yu_in = yu_ff;
      v_in = v_ff;           u_in = u_ff;          best_in = best_ff;
      first_in = first_ff;   best_set_in = best_set_ff;
      added_in = added_ff;   bestkey_in = bestkey_ff;
      op_in = op_ff;         sh_in = sh_ff;        my_in = my_ff;
      sq_in = sq_ff;         sum_in = sum_ff;      dist_in = dist_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;       res_in = res_ff;      one_in = one_ff;
      total_in = total_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_total_in = rsp_total_ff;
      rsp_count_in = rsp_count_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      if (cmd.capture) begin
         if (!full) count_in = count_ff + CW'(1);
         else       drop_in  = 1'b1;
      end
      if (cmd.start) begin
         u_in     = '0;
         first_in = 1'b1;
         added_in = CW'(1);
         total_in = '0;
      end
      if (cmd.ulatch) begin
         xu_in       = pt_x;
         yu_in       = pt_y;
         v_in        = AW'(1);
         best_set_in = 1'b0;
      end
      if (cmd.vcheck) begin
         op_in  = mag_x;
         sh_in  = mag_x;
         my_in  = mag_y;
         sq_in  = '0;
         cnt_in = '0;
      end
      if (cmd.mul_step) begin
         cnt_in = cnt_ff + MW'(1);
         if (cnt_ff == MW'(C - 1)) begin
            // x square done, start on y
            sum_in = {1'b0, sq_next};
            op_in  = my_ff;
            sh_in  = my_ff;
            sq_in  = '0;
         end else begin
            sq_in = sq_next;
            sh_in = {sh_ff[C-2:0], 1'b0};
         end
         if (cnt_ff == MW'(2 * C - 1)) dist_in = sum_ff + {1'b0, sq_next};
      end
      if (cmd.upd) begin
         if (!best_set_ff || (newkey < bestkey_ff)) begin
            best_in     = v_ff;
            bestkey_in  = newkey;
            best_set_in = 1'b1;
         end
      end
      if (cmd.vnext) v_in = v_ff + AW'(1);
      if (cmd.mark) begin
         u_in     = best_ff;
         first_in = 1'b0;
         added_in = added_ff + CW'(1);
         rem_in   = bestkey_ff;
         res_in   = '0;
         one_in   = DW'(1) << (2 * C);
      end
      if (cmd.sqrt_step) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            res_in = (res_ff >> 1) + one_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         one_in = one_ff >> 2;
      end
      if (cmd.acc) total_in = (len_sum > SW'(LEN_MAX)) ? LEN_MAX : len_sum[30:0];
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_total_in = total_ff;
         rsp_count_in = 7'(count_ff);
         rsp_ovf_in   = drop_ff;
         count_in     = '0;
         drop_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      xu_ff <= xu_in;          yu_ff <= yu_in;
      v_ff <= v_in;            u_ff <= u_in;          best_ff <= best_in;
      first_ff <= first_in;    best_set_ff <= best_set_in;
      added_ff <= added_in;    bestkey_ff <= bestkey_in;
      op_ff <= op_in;          sh_ff <= sh_in;        my_ff <= my_in;
      sq_ff <= sq_in;          sum_ff <= sum_in;      dist_ff <= dist_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;        res_ff <= res_in;      one_ff <= one_in;
      total_ff <= total_in;
      rsp_total_ff <= rsp_total_in;
      rsp_count_ff <= rsp_count_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign stat.single    = count_ff <= CW'(1);
   assign stat.skip      = !first_ff && key_rd_ff[DW];
   assign stat.mul_done  = cnt_ff == MW'(2 * C - 1);
   assign stat.scan_end  = CW'(v_ff) == (count_ff - CW'(1));
   assign stat.sqrt_done = one_ff[0];
   assign stat.all_added = added_ff == count_ff;
   assign stat.rsp_busy  = rsp_valid_ff && !rsp_ready;

   assign rsp_valid    = rsp_valid_ff;
   assign total_length = rsp_total_ff;
   assign point_count  = rsp_count_ff;
   assign overflow     = rsp_ovf_ff;

endmodule

[src/euclidean_mst_length.sv]
// top level of the euclidean minimum spanning tree length block
// depends on emst_pkg, emst_req_if, emst_rsp_if, emst_ctrl and emst_dp
//
// usage:
//   req carries one point per beat (point_x, point_y, last_point). points are
//   written to the point memory at one per cycle while req.ready is high. up
//   to MAX_POINTS points are kept; later ones are dropped and the result's
//   overflow bit is set. the beat with last_point starts the run and
//   req.ready stays low until the result is registered.
//   the run adds tree vertices one at a time (prim order over all pairs):
//   each of the n-1 passes reads and latches the newest vertex and scans
//   points 1 to n-1; each point not yet in the tree is read, checked, squared
//   by the bit-serial squarer and used to update its key; points already in
//   the tree are only read and checked. each pass ends with the square root
//   setup, the digit-by-digit square root and the saturating add. one point
//   gives a length of zero.
//   rsp carries one beat per set from an output register. a stalled result
//   holds; new points are taken meanwhile, and a run that finishes while the
//   old result still waits holds until it is taken.
//   reset is synchronous; it empties the point set and drops a pending result.
module euclidean_mst_length #(
   parameter int MAX_POINTS = 64,
   parameter int COORD_BITS = 24
) (
   input logic         clock,
   input logic         reset,
   emst_req_if.sink    req,
   emst_rsp_if.source  rsp
);
   import emst_pkg::*;

   cmd_type    cmd;
   status_type stat;

   emst_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req.valid),
      .in_last  (req.last_point),
      .in_ready (req.ready),
      .cmd      (cmd),
      .stat     (stat)
   );

   emst_dp #(
      .MAX_POINTS (MAX_POINTS),
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .in_x         (req.point_x),
      .in_y         (req.point_y),
      .cmd          (cmd),
      .stat         (stat),
      .rsp_ready    (rsp.ready),
      .rsp_valid    (rsp.valid),
      .total_length (rsp.total_length),
      .point_count  (rsp.point_count),
      .overflow     (rsp.overflow)
   );

   // a new result opens the point channel again
   a_ready_after_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp.valid) |-> req.ready)
      else $error("point channel not open after result");

   // dropped points only happen with a full store
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.overflow) |-> (rsp.point_count == 7'(MAX_POINTS)))
      else $error("overflow with store not full");

   // a single point has no edges
   a_single_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && (MAX_POINTS < 128) && (rsp.point_count == 7'd1))
         |-> (rsp.total_length == 31'd0))
      else $error("nonzero length for one point");

endmodule

[tb/tb_euclidean_mst_length.sv]
// testbench for euclidean_mst_length: drives point sets and checks each tree length
// against a prim-order predictor or typed rows; depends on emst_pkg, emst_req_if, emst_rsp_if
module tb_euclidean_mst_length;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_PTS = 64;
   localparam int CB      = 24;
   localparam logic signed [CB-1:0] C_MAX = 24'sh7FFFFF;
   localparam logic signed [CB-1:0] C_MIN = -24'sh800000;

   typedef struct {
      logic [30:0] total_length;
      logic [6:0]  point_count;
      logic        overflow;
   } tree_result_type;

   typedef struct {
      logic signed [CB-1:0] x;
      logic signed [CB-1:0] y;
      logic                 last;
      bit                   typed;
      logic [30:0]          len;
      logic [6:0]           cnt;
      logic                 ovf;
   } point_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic hold_off = 1'b0;
   int   fails = 0;
   int   items_sent = 0;

   tree_result_type tree_results_due[$];
   longint          set_x[MAX_PTS];
   longint          set_y[MAX_PTS];
   int              set_count = 0;
   bit              set_dropped = 0;

   emst_req_if #(.COORD_BITS(CB)) req_if();
   emst_rsp_if                    rsp_if();

   euclidean_mst_length #(.MAX_POINTS(MAX_PTS), .COORD_BITS(CB)) uut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   always #5 clock = ~clock;

   function automatic longint unsigned floor_root(longint unsigned v);
      longint unsigned r = 0;
      longint unsigned b = 64'h1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // mst weight multiset does not depend on the algorithm, so prim gives the same sum
   function automatic tree_result_type tree_length_of_set();
      tree_result_type res;
      longint unsigned best[MAX_PTS];
      bit              in_tree[MAX_PTS];
      longint unsigned total = 0;
      longint unsigned d2, dx, dy;
      int              pick;
      for (int i = 0; i < set_count; i++) begin
         best[i] = '1;
         in_tree[i] = 0;
      end
      best[0] = 0;
      for (int k = 0; k < set_count; k++) begin
         pick = -1;
         for (int i = 0; i < set_count; i++)
            if (!in_tree[i] && (pick < 0 || best[i] < best[pick])) pick = i;
         in_tree[pick] = 1;
         if (k > 0) total += floor_root(best[pick]);
         for (int i = 0; i < set_count; i++) begin
            if (!in_tree[i]) begin
               dx = (set_x[i] > set_x[pick]) ? set_x[i] - set_x[pick] : set_x[pick] - set_x[i];
               dy = (set_y[i] > set_y[pick]) ? set_y[i] - set_y[pick] : set_y[pick] - set_y[i];
               d2 = dx * dx + dy * dy;
               if (d2 < best[i]) best[i] = d2;
            end
         end
      end
      if (total > 64'd2147483647) total = 64'd2147483647;
      res.total_length = total[30:0];
      res.point_count  = set_count[6:0];
      res.overflow     = set_dropped;
      return res;
   endfunction

   task automatic send_point(input logic signed [CB-1:0] x, input logic signed [CB-1:0] y,
                             input logic last, input bit typed,
                             input tree_result_type typed_res);
      tree_result_type due_res;
      req_if.valid      <= 1'b1;
      req_if.point_x    <= x;
      req_if.point_y    <= y;
      req_if.last_point <= last;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      items_sent++;
      if (set_count < MAX_PTS) begin
         set_x[set_count] = x;
         set_y[set_count] = y;
         set_count++;
      end else begin
         set_dropped = 1;
      end
      if (last) begin
         due_res = typed ? typed_res : tree_length_of_set();
         tree_results_due.insert(tree_results_due.size(), due_res);
         set_count = 0;
         set_dropped = 0;
      end
      // bursts of random length, then a random gap
      if ($urandom_range(0, 5) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   function automatic logic signed [CB-1:0] rand_coord(int mode);
      case (mode)
         0: return CB'($urandom);
         1: return CB'($signed($urandom_range(0, 4095)) - 2048);
         2: return $urandom_range(0, 1) ? C_MAX : C_MIN;
         default: return CB'($signed($urandom_range(0, 65535)) - 32768);
      endcase
   endfunction

   task automatic send_set(int n);
      tree_result_type none;
      int mode;
      none = '{default: 0};
      mode = $urandom_range(0, 3);
      for (int i = 0; i < n; i++)
         send_point(rand_coord(mode), rand_coord(mode), i == n - 1, 0, none);
   endtask

   initial begin
      point_row_type   rows[$];
      tree_result_type r;
      int              n;
      req_if.valid      = 1'b0;
      req_if.point_x    = '0;
      req_if.point_y    = '0;
      req_if.last_point = 1'b0;
      rows = '{
         '{C_MAX, C_MIN, 1, 1, 31'd0, 7'd1, 1'b0},
         '{C_MIN, C_MAX, 1, 1, 31'd0, 7'd1, 1'b0},
         '{24'sd0, 24'sd0, 0, 0, 0, 0, 0},
         '{24'sd768, 24'sd1024, 1, 1, 31'd1280, 7'd2, 1'b0},
         '{C_MIN, C_MIN, 0, 0, 0, 0, 0},
         '{C_MAX, C_MAX, 1, 0, 0, 0, 0},
         '{C_MIN, 24'sd0, 0, 0, 0, 0, 0},
         '{C_MAX, 24'sd0, 0, 0, 0, 0, 0},
         '{24'sd0, C_MIN, 0, 0, 0, 0, 0},
         '{24'sd0, C_MAX, 1, 0, 0, 0, 0},
         '{24'sd5, 24'sd5, 0, 0, 0, 0, 0},
         '{24'sd5, 24'sd5, 0, 0, 0, 0, 0},
         '{24'sd5, 24'sd5, 1, 1, 31'd0, 7'd3, 1'b0},
         '{-24'sd256, 24'sd100, 0, 0, 0, 0, 0},
         '{24'sd300, -24'sd77, 0, 0, 0, 0, 0},
         '{24'sd1, 24'sd2000, 0, 0, 0, 0, 0},
         '{-24'sd900, -24'sd900, 1, 0, 0, 0, 0}
      };
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (rows[i]) begin
         r = '{rows[i].len, rows[i].cnt, rows[i].ovf};
         send_point(rows[i].x, rows[i].y, rows[i].last, rows[i].typed, r);
      end
      // full store, then an overflowing set that ends on a dropped point
      send_set(MAX_PTS);
      send_set(MAX_PTS + $urandom_range(1, 3));
      while (items_sent < 1950) begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 8);
         send_set(n);
      end
      req_if.valid <= 1'b0;
      while (tree_results_due.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fails == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // long receiver stall while points keep coming
   initial begin
      wait (items_sent >= 300);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (5000) @(posedge clock);
      hold_off <= 1'b0;
   end

   int stall_cycle = 0;
   always @(posedge clock) begin
      stall_cycle <= stall_cycle + 1;
      if (reset || hold_off) begin
         rsp_if.ready <= 1'b0;
      end else begin
         case ((stall_cycle / 700) % 3)
            0: rsp_if.ready <= 1'b1;
            1: rsp_if.ready <= ($urandom_range(0, 3) != 0);
            default: rsp_if.ready <= 1'($urandom_range(0, 1));
         endcase
      end
   end

   always @(posedge clock) begin
      tree_result_type due;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (tree_results_due.size() == 0) begin
            $error("result beat with nothing expected");
            fails++;
         end else begin
            due = tree_results_due.pop_front();
            if (rsp_if.total_length !== due.total_length) begin
               $error("total_length expected %0d actual %0d", due.total_length,
                      rsp_if.total_length);
               fails++;
            end
            if (rsp_if.point_count !== due.point_count) begin
               $error("point_count expected %0d actual %0d", due.point_count,
                      rsp_if.point_count);
               fails++;
            end
            if (rsp_if.overflow !== due.overflow) begin
               $error("overflow expected %0d actual %0d", due.overflow, rsp_if.overflow);
               fails++;
            end
         end
      end
   end

   initial begin
      #60_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

[euclidean_mst_length.f]
src/emst_pkg.sv
src/emst_req_if.sv
src/emst_rsp_if.sv
src/emst_ctrl.sv
src/emst_dp.sv
src/euclidean_mst_length.sv
tb/tb_euclidean_mst_length.sv
